>>> design/mlt_pkg.sv
// Shared types and constants of the MAC learning table.
`timescale 1ns / 1ps
package mlt_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 20;
  localparam int unsigned WAYS_DEF        = 4;

  localparam int unsigned HASH_MUL  = 29 * 11;
  localparam int unsigned HASH_DIV  = 19;
  localparam int unsigned MAC_LOW_W = 24;

  localparam int unsigned BKT_W = 6;

  localparam logic [15:0] AGE_LIMIT_RST    = 16'd300;
  localparam logic [11:0] DEFAULT_VLAN_RST = 12'd1;

  localparam logic [1:0] CMD_LEARN  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_SWEEP  = 2'd3;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_REFRESH = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;
  localparam logic [2:0] ST_TICKED  = 3'd5;
  localparam logic [2:0] ST_SWEPT   = 3'd6;

  localparam logic ADDR_AGE_LIMIT    = 1'b0;
  localparam logic ADDR_DEFAULT_VLAN = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic [47:0]      mac;
    logic             vlan_tagged;
    logic [11:0]      vlan_id;
    logic [4:0]       ingress_port;
    logic [BKT_W-1:0] bucket;
  } item_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [11:0] vlan;
    logic [4:0]  port;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [15:0] age_limit;
    logic [11:0] default_vlan;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [4:0]  out_port;
    logic [11:0] out_vlan;
    logic [31:0] entry_age;
    logic [6:0]  removed_count;
    logic [4:0]  bucket_index;
  } res_t;

endpackage

>>> design/mlt_if.sv
// Command and result channel interfaces of the MAC learning table.
`timescale 1ns / 1ps
interface mlt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [47:0] mac;
  logic        vlan_tagged;
  logic [11:0] vlan_id;
  logic [4:0]  ingress_port;

  modport source(output valid, command, mac, vlan_tagged, vlan_id, ingress_port,
                 input ready);
  modport sink(input valid, command, mac, vlan_tagged, vlan_id, ingress_port,
               output ready);
endinterface

interface mlt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hit;
  logic [4:0]  out_port;
  logic [11:0] out_vlan;
  logic [31:0] entry_age;
  logic [6:0]  removed_count;
  logic [4:0]  bucket_index;

  modport source(output valid, status, hit, out_port, out_vlan, entry_age, removed_count,
                 bucket_index, input ready);
  modport sink(input valid, status, hit, out_port, out_vlan, entry_age, removed_count,
               bucket_index, output ready);
endinterface

>>> design/mac_learning_table_with_aging.sv
// Top level of the MAC learning table with aging.
// Each command beat yields one result beat, in order. The front end takes a beat and
// hashes a learn or lookup MAC in its hash, mod and remainder states (reciprocal multiply
// for the quotient, reciprocal multiply and subtract for the bucket); it takes no new beat
// until it has pushed the last one on. A two-entry queue parts it from the table
// engine, which reads the ways of the bucket one at a time from a single registered-read
// RAM: a learn or lookup reads and compares each way of its bucket, then writes (on a
// learn) and answers; a tick advances the seconds count and answers; a sweep reads and
// checks every entry of the table, then answers. The engine takes its next beat only
// after its result beat has been taken.
// Valid bits sit in flip-flops and clear at reset; there is no clearing pass.
`timescale 1ns / 1ps
module mac_learning_table_with_aging #(
  parameter int unsigned NUM_BUCKETS = mlt_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = mlt_pkg::WAYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlt_in_if.sink      in_i,
  mlt_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mlt_pkg::cfg_t  cfg_q;
  mlt_pkg::item_t f_item, b_item;
  mlt_pkg::res_t  res;
  logic           f_valid, f_ready, b_valid, b_ready;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.age_limit    <= mlt_pkg::AGE_LIMIT_RST;
      cfg_q.default_vlan <= mlt_pkg::DEFAULT_VLAN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == mlt_pkg::ADDR_AGE_LIMIT) begin
        cfg_q.age_limit <= pwdata[15:0];
      end else begin
        cfg_q.default_vlan <= pwdata[11:0];
      end
    end
  end

  assign prdata = (paddr[2] == mlt_pkg::ADDR_DEFAULT_VLAN) ? {20'd0, cfg_q.default_vlan}
                                                           : {16'd0, cfg_q.age_limit};

  mlt_front #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_o      (f_item),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready)
  );

  mlt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_item_i (f_item),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .pop_item_o  (b_item),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready)
  );

  mlt_back #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (b_item),
    .item_valid_i(b_valid),
    .item_ready_o(b_ready),
    .res_o       (res),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready)
  );

  assign out_o.status        = res.status;
  assign out_o.hit           = res.hit;
  assign out_o.out_port      = res.out_port;
  assign out_o.out_vlan      = res.out_vlan;
  assign out_o.entry_age     = res.entry_age;
  assign out_o.removed_count = res.removed_count;
  assign out_o.bucket_index  = res.bucket_index;

  a_cfg_age_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[2] == mlt_pkg::ADDR_AGE_LIMIT) |=> cfg_q.age_limit == $past(pwdata[15:0]))
    else $error("age limit write lost");

  a_tick_sweep_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == mlt_pkg::ST_TICKED || out_o.status == mlt_pkg::ST_SWEPT))
    |-> (!out_o.hit && out_o.bucket_index == 5'd0))
    else $error("tick or sweep beat carries table data");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == mlt_pkg::ST_MISS)
    |-> (!out_o.hit && out_o.out_port == 5'd0 && out_o.entry_age == 32'd0))
    else $error("miss beat carries entry data");

  a_hit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.hit == (out_o.status == mlt_pkg::ST_HIT ||
                                   out_o.status == mlt_pkg::ST_REFRESH)))
    else $error("hit flag disagrees with status");

endmodule

>>> design/mlt_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module mlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mlt_front.sv
// Front end: accepts command beats and hashes the MAC to its bucket.
`timescale 1ns / 1ps
module mlt_front #(
  parameter int unsigned NUM_BUCKETS = mlt_pkg::NUM_BUCKETS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mlt_in_if.sink        in_i,
  output mlt_pkg::item_t item_o,
  output logic          item_valid_o,
  input  logic          item_ready_i
);

  localparam int unsigned QI  = mlt_pkg::HASH_MUL / mlt_pkg::HASH_DIV;
  localparam int unsigned QR  = mlt_pkg::HASH_MUL % mlt_pkg::HASH_DIV;
  localparam int unsigned XW  = mlt_pkg::MAC_LOW_W + $clog2(QR + 1);
  localparam int unsigned QW  = mlt_pkg::MAC_LOW_W + $clog2(QI + 1);
  localparam int unsigned DSH = XW + $clog2(mlt_pkg::HASH_DIV);
  localparam int unsigned MSH = QW + $clog2(NUM_BUCKETS);
  localparam longint unsigned DREC =
    ((64'd1 << DSH) + 64'(mlt_pkg::HASH_DIV) - 64'd1) / 64'(mlt_pkg::HASH_DIV);
  localparam longint unsigned MREC =
    ((64'd1 << MSH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_MOD, S_REM, S_PUSH} state_e;

  state_e         state_q;
  mlt_pkg::item_t item_q;
  logic [XW-1:0]  x_q;
  logic [QW-1:0]  q_q, d_q;
  logic [63:0]    dprod, mprod;

  // quotient of the product by the divisor, then quotient by the bucket count
  assign dprod = 64'(x_q) * DREC;
  assign mprod = 64'(q_q) * MREC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      item_q  <= '0;
      x_q     <= '0;
      q_q     <= '0;
      d_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            item_q.command      <= in_i.command;
            item_q.mac          <= in_i.mac;
            item_q.vlan_tagged  <= in_i.vlan_tagged;
            item_q.vlan_id      <= in_i.vlan_id;
            item_q.ingress_port <= in_i.ingress_port;
            item_q.bucket       <= '0;
            x_q <= XW'(64'(in_i.mac[mlt_pkg::MAC_LOW_W-1:0]) * 64'(QR));
            if (in_i.command == mlt_pkg::CMD_LEARN || in_i.command == mlt_pkg::CMD_LOOKUP) begin
              state_q <= S_HASH;
            end else begin
              state_q <= S_PUSH;
            end
          end
        end
        S_HASH: begin
          q_q     <= QW'(64'(item_q.mac[mlt_pkg::MAC_LOW_W-1:0]) * 64'(QI)) +
                     QW'(dprod >> DSH);
          state_q <= S_MOD;
        end
        S_MOD: begin
          d_q     <= QW'(mprod >> MSH);
          state_q <= S_REM;
        end
        S_REM: begin
          item_q.bucket <= mlt_pkg::BKT_W'(q_q - QW'(64'(d_q) * 64'(NUM_BUCKETS)));
          state_q       <= S_PUSH;
        end
        S_PUSH: begin
          if (item_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign item_o       = item_q;
  assign item_valid_o = (state_q == S_PUSH);

endmodule

>>> design/mlt_queue.sv
// Two-entry queue between the front end and the table engine.
`timescale 1ns / 1ps
module mlt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mlt_pkg::item_t push_item_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output mlt_pkg::item_t pop_item_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  mlt_pkg::item_t slot_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/mlt_back.sv
// Table engine: bucket search, learn, lookup, tick and aging sweep.
`timescale 1ns / 1ps
module mlt_back #(
  parameter int unsigned NUM_BUCKETS = mlt_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = mlt_pkg::WAYS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mlt_pkg::cfg_t  cfg_i,
  input  mlt_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  output mlt_pkg::res_t  res_o,
  output logic           res_valid_o,
  input  logic           res_ready_i
);

  localparam int unsigned N   = NUM_BUCKETS * WAYS;
  localparam int unsigned EW  = $clog2(N);
  localparam int unsigned WCW = $clog2(WAYS + 1);

  typedef enum logic [2:0] {S_IDLE, S_LRD, S_LCMP, S_LDONE, S_SRD, S_SCMP} state_e;

  state_e          state_q;
  mlt_pkg::item_t  cur_q;
  logic [EW-1:0]   e_q;
  logic [WCW-1:0]  way_q;
  logic            found_q, free_q;
  logic [EW-1:0]   fnd_e_q, free_e_q;
  mlt_pkg::entry_t fnd_q;
  logic [31:0]     secs_q;
  logic [N-1:0]    valid_q;
  logic [6:0]      removed_q;
  mlt_pkg::res_t   res_q;
  logic            res_valid_q;

  mlt_pkg::entry_t rd, wdata;
  logic            we, re;
  logic [EW-1:0]   waddr;
  logic [31:0]     sweep_age;

  mlt_ram #(
    .WIDTH($bits(mlt_pkg::entry_t)),
    .DEPTH(N)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(e_q),
    .rdata_o(rd)
  );

  assign re        = (state_q == S_LRD) || (state_q == S_SRD);
  assign sweep_age = secs_q - rd.stamp;

  always_comb begin
    we    = 1'b0;
    waddr = fnd_e_q;
    wdata = fnd_q;
    if (state_q == S_LDONE && cur_q.command == mlt_pkg::CMD_LEARN) begin
      if (found_q) begin
        we          = 1'b1;
        wdata.port  = cur_q.ingress_port;
        wdata.stamp = secs_q;
      end else if (free_q) begin
        we          = 1'b1;
        waddr       = free_e_q;
        wdata.mac   = cur_q.mac;
        wdata.vlan  = cur_q.vlan_tagged ? cur_q.vlan_id : cfg_i.default_vlan;
        wdata.port  = cur_q.ingress_port;
        wdata.stamp = secs_q;
      end
    end
  end

  assign item_ready_o = (state_q == S_IDLE) && !res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      e_q         <= '0;
      way_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      fnd_e_q     <= '0;
      free_e_q    <= '0;
      fnd_q       <= '0;
      secs_q      <= '0;
      valid_q     <= '0;
      removed_q   <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_valid_i && !res_valid_q) begin
            cur_q     <= item_i;
            found_q   <= 1'b0;
            free_q    <= 1'b0;
            way_q     <= '0;
            removed_q <= '0;
            case (item_i.command)
              mlt_pkg::CMD_TICK: begin
                secs_q      <= secs_q + 32'd1;
                res_q       <= '{status: mlt_pkg::ST_TICKED, default: '0};
                res_valid_q <= 1'b1;
              end
              mlt_pkg::CMD_SWEEP: begin
                res_q   <= '0;
                e_q     <= '0;
                state_q <= S_SRD;
              end
              default: begin
                res_q   <= '0;
                e_q     <= EW'(int'(item_i.bucket) * WAYS);
                state_q <= S_LRD;
              end
            endcase
          end
        end
        S_LRD: state_q <= S_LCMP;
        S_LCMP: begin
          if (valid_q[e_q]) begin
            if (!found_q && rd.mac == cur_q.mac) begin
              found_q <= 1'b1;
              fnd_e_q <= e_q;
              fnd_q   <= rd;
            end
          end else if (!free_q) begin
            free_q   <= 1'b1;
            free_e_q <= e_q;
          end
          if (way_q == WCW'(WAYS - 1)) begin
            state_q <= S_LDONE;
          end else begin
            way_q   <= way_q + 1'b1;
            e_q     <= e_q + 1'b1;
            state_q <= S_LRD;
          end
        end
        S_LDONE: begin
          res_q.bucket_index <= 5'(cur_q.bucket);
          res_q.hit          <= found_q;
          if (cur_q.command == mlt_pkg::CMD_LEARN) begin
            if (found_q) begin
              res_q.status <= mlt_pkg::ST_REFRESH;
            end else if (free_q) begin
              res_q.status      <= mlt_pkg::ST_NEW;
              valid_q[free_e_q] <= 1'b1;
            end else begin
              res_q.status <= mlt_pkg::ST_FULL;
            end
          end else if (found_q) begin
            res_q.status    <= mlt_pkg::ST_HIT;
            res_q.out_port  <= fnd_q.port;
            res_q.out_vlan  <= fnd_q.vlan;
            res_q.entry_age <= secs_q - fnd_q.stamp;
          end else begin
            res_q.status <= mlt_pkg::ST_MISS;
          end
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_SRD: state_q <= S_SCMP;
        S_SCMP: begin
          if (valid_q[e_q] && sweep_age > {16'd0, cfg_i.age_limit}) begin
            valid_q[e_q] <= 1'b0;
            if (removed_q != 7'd127) begin
              removed_q <= removed_q + 7'd1;
            end
          end
          if (e_q == EW'(N - 1)) begin
            res_q.status        <= mlt_pkg::ST_SWEPT;
            res_q.removed_count <= (valid_q[e_q] && sweep_age > {16'd0, cfg_i.age_limit} &&
                                    removed_q != 7'd127) ? removed_q + 7'd1 : removed_q;
            res_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end else begin
            e_q     <= e_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule
